// ===== hdl/fcptp_pkg.sv =====
// ----------------------------------------------------------------------------
// fcptp_pkg
// Types, codes and helpers shared by the FCP TLV response parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fcptp_pkg;

    localparam int MAX_RESPONSE_BYTES_DEF = 512;

    localparam int LEN_W   = 10;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;

    // Element walk phases
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_TAG    = 2'd1,
        PH_LEN    = 2'd2,
        PH_VALUE  = 2'd3
    } phase_t;

    // Field kinds
    localparam logic [KIND_W-1:0] KIND_RSVD_MEM = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DESC     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FILE_ID  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DF_NAME  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STATUS   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 3'd7;

    // Known tags
    localparam logic [BYTE_W-1:0] TAG_RSVD_MEM = 8'h80;
    localparam logic [BYTE_W-1:0] TAG_DESC     = 8'h82;
    localparam logic [BYTE_W-1:0] TAG_FILE_ID  = 8'h83;
    localparam logic [BYTE_W-1:0] TAG_DF_NAME  = 8'h84;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_byte;
        logic [LEN_W-1:0]  response_length;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] field_kind;
        logic [BYTE_W-1:0] value_byte;
        logic [BYTE_W-1:0] value_index;
        logic              last_of_field;
    } out_item_t;

    function automatic logic [KIND_W-1:0] kind_of_tag(input logic [BYTE_W-1:0] tag);
        logic [KIND_W-1:0] k;
        begin
            case (tag)
                TAG_RSVD_MEM: k = KIND_RSVD_MEM;
                TAG_DESC:     k = KIND_DESC;
                TAG_FILE_ID:  k = KIND_FILE_ID;
                TAG_DF_NAME:  k = KIND_DF_NAME;
                default:      k = KIND_UNKNOWN;
            endcase
            return k;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/fcp_tlv_response_parser_core.sv =====
// ----------------------------------------------------------------------------
// fcp_tlv_response_parser_core
// Streaming parser of a SELECT response FCP template and its status bytes.
// ----------------------------------------------------------------------------
// Each result is registered and appears on out_* in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the single result register sets the pace,
// and in_ready drops only while that register is full and not being taken.
// Reset (rst_n, async, active low) empties the result register, sets
// parse_mode to 1 and starts as if a zero-length response had begun.
`default_nettype none

module fcp_tlv_response_parser_core
    import fcptp_pkg::*;
#(
    parameter int MAX_RESPONSE_BYTES = MAX_RESPONSE_BYTES_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic      cfg_data,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    logic      accept;
    logic      res_valid;
    out_item_t res;

    assign accept = in_valid && in_ready;

    fcptp_parser #(
        .MAX_RESPONSE_BYTES (MAX_RESPONSE_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res       (res)
    );

    fcptp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && res_valid),
        .load_data (res),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== hdl/fcptp_parser.sv =====
// ----------------------------------------------------------------------------
// fcptp_parser
// Per-byte parse state and element walk; produces at most one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module fcptp_parser
    import fcptp_pkg::*;
#(
    parameter int MAX_RESPONSE_BYTES = MAX_RESPONSE_BYTES_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic      cfg_data,
    input  wire logic      accept,
    input  wire in_item_t  in_data,
    output logic           res_valid,
    output out_item_t      res
);

    localparam int                LEN_CAP   = (MAX_RESPONSE_BYTES > 1023) ? 1023
                                                                          : MAX_RESPONSE_BYTES;
    localparam logic [LEN_W-1:0]  LEN_CAP_V = LEN_W'(LEN_CAP);
    localparam logic [LEN_W-1:0]  POS_MAX   = {LEN_W{1'b1}};

    logic              mode_reg;
    logic [LEN_W-1:0]  pos_reg,   pos_next;
    logic [LEN_W-1:0]  be_reg,    be_next;
    phase_t            phase_reg, phase_next;
    logic [KIND_W-1:0] kind_reg,  kind_next;
    logic [BYTE_W-1:0] left_reg,  left_next;
    logic [BYTE_W-1:0] cnt_reg,   cnt_next;

    // state as seen by this beat, after a possible restart
    logic [LEN_W-1:0]  len_clip;
    logic [LEN_W-1:0]  pos_e, be_e;
    phase_t            phase_e;
    logic [KIND_W-1:0] kind_e;
    logic [BYTE_W-1:0] left_e, cnt_e;
    logic              in_status;
    logic [LEN_W-1:0]  si;

    always_comb
    begin
        len_clip = (in_data.response_length > LEN_CAP_V) ? LEN_CAP_V
                                                          : in_data.response_length;
        if (in_data.first_byte)
        begin
            be_e    = (len_clip >= LEN_W'(2)) ? len_clip - LEN_W'(2) : '0;
            pos_e   = '0;
            phase_e = PH_HEADER;
            kind_e  = KIND_RSVD_MEM;
            left_e  = '0;
            cnt_e   = '0;
        end
        else
        begin
            be_e    = be_reg;
            pos_e   = pos_reg;
            phase_e = phase_reg;
            kind_e  = kind_reg;
            left_e  = left_reg;
            cnt_e   = cnt_reg;
        end
        in_status = (pos_e >= be_e);
        si        = pos_e - be_e;
    end

    // next state
    always_comb
    begin
        be_next    = be_e;
        phase_next = phase_e;
        kind_next  = kind_e;
        left_next  = left_e;
        cnt_next   = cnt_e;
        pos_next   = (pos_e != POS_MAX) ? pos_e + LEN_W'(1) : pos_e;
        if (!in_status)
        begin
            unique case (phase_e)
                PH_HEADER:
                begin
                    if (pos_e >= LEN_W'(1))
                        phase_next = PH_TAG;
                end
                PH_TAG:
                begin
                    kind_next  = kind_of_tag(in_data.data_byte);
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    left_next  = in_data.data_byte;
                    cnt_next   = '0;
                    phase_next = (in_data.data_byte == '0) ? PH_TAG : PH_VALUE;
                end
                PH_VALUE:
                begin
                    cnt_next  = cnt_e + BYTE_W'(1);
                    left_next = left_e - BYTE_W'(1);
                    if (left_e == BYTE_W'(1))
                        phase_next = PH_TAG;
                end
                default: phase_next = PH_HEADER;
            endcase
        end
    end

    // result
    logic fixed, known, take;

    always_comb
    begin
        fixed     = (kind_e == KIND_RSVD_MEM) || (kind_e == KIND_FILE_ID);
        known     = (kind_e <= KIND_DF_NAME);
        take      = known && (!fixed || cnt_e < BYTE_W'(2));
        res_valid = 1'b0;
        res       = '0;
        if (in_status)
        begin
            if (si < LEN_W'(2))
            begin
                res_valid         = 1'b1;
                res.field_kind    = KIND_STATUS;
                res.value_byte    = in_data.data_byte;
                res.value_index   = BYTE_W'(si);
                res.last_of_field = (si == LEN_W'(1));
            end
        end
        else if (phase_e == PH_VALUE && take && mode_reg)
        begin
            res_valid         = 1'b1;
            res.field_kind    = kind_e;
            res.value_byte    = in_data.data_byte;
            res.value_index   = cnt_e;
            res.last_of_field = (left_e == BYTE_W'(1))
                             || ({1'b0, pos_e} + (LEN_W+1)'(1) == {1'b0, be_e})
                             || (fixed && cnt_e == BYTE_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b1;
            pos_reg   <= '0;
            be_reg    <= '0;
            phase_reg <= PH_HEADER;
            kind_reg  <= KIND_RSVD_MEM;
            left_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_data;
            if (accept)
            begin
                pos_reg   <= pos_next;
                be_reg    <= be_next;
                phase_reg <= phase_next;
                kind_reg  <= kind_next;
                left_reg  <= left_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fcptp_out_reg.sv =====
// ----------------------------------------------------------------------------
// fcptp_out_reg
// Result register with valid/ready; frees the input side as it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module fcptp_out_reg
    import fcptp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      load,
    input  wire out_item_t load_data,
    output logic           space,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    logic      valid_reg, valid_next;
    out_item_t data_reg;

    assign space     = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // hold payload until a new beat replaces it
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

endmodule

`default_nettype wire

// ===== hdl/fcptp_checker.sv =====
// ----------------------------------------------------------------------------
// fcptp_checker
// Port-level checks for the FCP TLV response parser.
// ----------------------------------------------------------------------------
`default_nettype none

module fcptp_checker
    import fcptp_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // input side frees up whenever the result register drains
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not track result register space");

    // status bytes: index 0 or 1, last on index 1
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.field_kind == KIND_STATUS
        |-> out_data.value_index <= 8'd1
            && out_data.last_of_field == (out_data.value_index == 8'd1))
        else $error("bad status byte numbering");

    // fixed-size fields stop at two bytes, and the second one is last
    a_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.field_kind == KIND_RSVD_MEM
                      || out_data.field_kind == KIND_FILE_ID)
        && out_data.value_index != 8'd0
        |-> out_data.value_index == 8'd1 && out_data.last_of_field)
        else $error("fixed-size field overrun");

endmodule

bind fcp_tlv_response_parser_core fcptp_checker u_fcptp_checker (.*);

`default_nettype wire

// ===== bench/fcp_tlv_response_parser_core_tb.sv =====
// ----------------------------------------------------------------------------
// fcp_tlv_response_parser_core_tb
// Drives SELECT responses byte by byte through the FCP TLV parser, predicts
// every delivered field byte and status byte, and compares each output beat
// in order. Both handshakes idle in random bursts; parse mode is switched
// between phases while the parser is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_tlv_response_parser_core_tb;
    import fcptp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 200;

    class fcp_field_scoreboard;
        bit               mode;
        logic [LEN_W-1:0] pos;
        logic [LEN_W-1:0] body_end;
        phase_t           phase;
        logic [2:0]       kind;
        logic [7:0]       left;
        logic [7:0]       count;
        out_item_t        expected_fields[$];
        int               errors;
        int               matched;
        int               status_seen;
        int               bytes_in;

        function new();
            mode        = 1'b1;
            pos         = '0;
            body_end    = '0;
            phase       = PH_HEADER;
            kind        = KIND_RSVD_MEM;
            left        = '0;
            count       = '0;
            errors      = 0;
            matched     = 0;
            status_seen = 0;
            bytes_in    = 0;
        endfunction

        function int pending();
            return expected_fields.size();
        endfunction

        // Advance the parser state by one accepted byte and queue its result.
        function void note_byte(in_item_t it);
            logic [LEN_W-1:0] len;
            logic [LEN_W-1:0] si;
            logic [7:0]       b;
            bit               fixed;
            bit               take;
            out_item_t        f;
            b = it.data_byte;
            bytes_in++;
            if (it.first_byte)
            begin
                len = it.response_length;
                if (len > MAX_RESPONSE_BYTES_DEF)
                    len = LEN_W'(MAX_RESPONSE_BYTES_DEF);
                body_end = (len >= LEN_W'(2)) ? len - LEN_W'(2) : '0;
                pos      = '0;
                phase    = PH_HEADER;
                kind     = KIND_RSVD_MEM;
                left     = '0;
                count    = '0;
            end
            if (pos >= body_end)
            begin
                si = pos - body_end;
                if (si < 2)
                begin
                    f.field_kind    = KIND_STATUS;
                    f.value_byte    = b;
                    f.value_index   = 8'(si);
                    f.last_of_field = (si == 1);
                    expected_fields.push_back(f);
                end
            end
            else
            begin
                case (phase)
                    PH_HEADER:
                    begin
                        if (pos >= 1)
                            phase = PH_TAG;
                    end
                    PH_TAG:
                    begin
                        case (b)
                            TAG_RSVD_MEM: kind = KIND_RSVD_MEM;
                            TAG_DESC:     kind = KIND_DESC;
                            TAG_FILE_ID:  kind = KIND_FILE_ID;
                            TAG_DF_NAME:  kind = KIND_DF_NAME;
                            default:      kind = KIND_UNKNOWN;
                        endcase
                        phase = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        left  = b;
                        count = '0;
                        phase = (b == 0) ? PH_TAG : PH_VALUE;
                    end
                    default:
                    begin
                        // reserved memory and file id carry two bytes at most
                        fixed = (kind == KIND_RSVD_MEM) || (kind == KIND_FILE_ID);
                        take  = (kind <= KIND_DF_NAME) && (!fixed || count < 2);
                        if (take && mode)
                        begin
                            f.field_kind    = kind;
                            f.value_byte    = b;
                            f.value_index   = count;
                            f.last_of_field = (left == 1) || (pos + 1 == body_end) ||
                                              (fixed && count == 1);
                            expected_fields.push_back(f);
                        end
                        count = count + 8'd1;
                        left  = left - 8'd1;
                        if (left == 0)
                            phase = PH_TAG;
                    end
                endcase
            end
            if (pos < 1023)
                pos = pos + LEN_W'(1);
        endfunction

        task report(input string msg);
            errors++;
            // keep the log short when the block is badly off
            if (errors <= REPORT_LIMIT)
                $display("ERROR %0t: %s", $time, msg);
        endtask

        task check_field(input out_item_t got);
            out_item_t want;
            bit        ok;
            if (expected_fields.size() == 0)
            begin
                report($sformatf("unexpected beat kind=%0d byte=%02h idx=%0d last=%0b",
                                 got.field_kind, got.value_byte, got.value_index,
                                 got.last_of_field));
                return;
            end
            want = expected_fields.pop_front();
            ok = 1'b1;
            if (got.field_kind !== want.field_kind)
            begin
                ok = 1'b0;
                report($sformatf("field_kind %0d, want %0d", got.field_kind, want.field_kind));
            end
            if (got.value_byte !== want.value_byte)
            begin
                ok = 1'b0;
                report($sformatf("value_byte %02h, want %02h", got.value_byte, want.value_byte));
            end
            if (got.value_index !== want.value_index)
            begin
                ok = 1'b0;
                report($sformatf("value_index %0d, want %0d", got.value_index,
                                 want.value_index));
            end
            if (got.last_of_field !== want.last_of_field)
            begin
                ok = 1'b0;
                report($sformatf("last_of_field %0b, want %0b", got.last_of_field,
                                 want.last_of_field));
            end
            if (ok)
                matched++;
            if (want.field_kind == KIND_STATUS)
                status_seen++;
        endtask
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic      cfg_data  = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    fcp_field_scoreboard fields = new();

    bit calm       = 1'b0;
    bit no_idle    = 1'b0;
    int out_hold   = 0;
    int responses  = 0;

    fcp_tlv_response_parser_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always #5 clk = ~clk;

    // Receiver: stall in random bursts.
    always @(posedge clk)
    begin
        if (out_hold != 0)
        begin
            out_hold  <= out_hold - 1;
            out_ready <= 1'b0;
        end
        else if (!no_idle && !calm && $urandom_range(0, 7) == 0)
        begin
            out_hold  <= $urandom_range(0, 18);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            fields.check_field(out_data);
    end

    task automatic send_byte(input logic [7:0] b, input bit first, input logic [LEN_W-1:0] len);
        in_item_t it;
        it.data_byte       = b;
        it.first_byte      = first;
        it.response_length = len;
        if (!no_idle && !calm && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        fields.note_byte(it);
    endtask

    task automatic write_mode(input bit m);
        in_valid <= 1'b0;
        while (fields.pending() != 0)
            @(posedge clk);
        // let a byte with no result finish inside the block
        repeat (3) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we      <= 1'b0;
        fields.mode  = m;
    endtask

    // One response: outer header, TLV elements cut at the body end, status.
    // Some are broken: wrong length field, short length, or trailing bytes.
    task automatic send_response();
        logic [7:0]       body[$];
        logic [7:0]       tag;
        logic [LEN_W-1:0] len_field;
        int               body_len;
        int               elen;
        int               extra;
        int               i;
        responses++;
        calm     = ($urandom_range(0, 3) == 0);
        body_len = ($urandom_range(0, 29) == 0) ? $urandom_range(200, 510)
                                                : $urandom_range(2, 40);
        body.push_back(8'h62);
        body.push_back(8'(body_len - 2));
        while (body.size() < body_len)
        begin
            case ($urandom_range(0, 5))
                0:       tag = TAG_RSVD_MEM;
                1:       tag = TAG_DESC;
                2:       tag = TAG_FILE_ID;
                3:       tag = TAG_DF_NAME;
                default: tag = 8'($urandom);
            endcase
            if ($urandom_range(0, 7) == 0)
                elen = $urandom_range(0, 255);
            else if (tag == TAG_RSVD_MEM || tag == TAG_FILE_ID)
                elen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 2;
            else
                elen = $urandom_range(0, 16);
            body.push_back(tag);
            body.push_back(8'(elen));
            repeat (elen) body.push_back(8'($urandom));
        end
        len_field = LEN_W'(body_len + 2);
        extra     = 0;
        if ($urandom_range(0, 4) == 0)
        begin
            case ($urandom_range(0, 2))
                0:       len_field = LEN_W'($urandom_range(0, 1023));
                1:       len_field = LEN_W'($urandom_range(0, 3));
                default: extra = $urandom_range(1, 4);
            endcase
        end
        for (i = 0; i < body_len; i++)
            send_byte(body[i], i == 0,
                      (i == 0) ? len_field : LEN_W'($urandom_range(0, 1023)));
        if ($urandom_range(0, 1) == 0)
        begin
            send_byte(8'h90, 1'b0, LEN_W'($urandom_range(0, 1023)));
            send_byte(8'h00, 1'b0, LEN_W'($urandom_range(0, 1023)));
        end
        else
        begin
            send_byte(8'($urandom), 1'b0, LEN_W'($urandom_range(0, 1023)));
            send_byte(8'($urandom), 1'b0, LEN_W'($urandom_range(0, 1023)));
        end
        repeat (extra) send_byte(8'($urandom), 1'b0, LEN_W'($urandom_range(0, 1023)));
    endtask

    initial
    begin
        logic [7:0] directed_resp[$];
        int         budget[4];
        int         target;
        int         ph;
        int         i;
        int         drain;
        directed_resp = '{8'h62, 8'h12,
                          TAG_RSVD_MEM, 8'h03, 8'h00, 8'hFF, 8'h7E,
                          TAG_DESC, 8'h01, 8'h38,
                          TAG_FILE_ID, 8'h02, 8'h3F, 8'h00,
                          TAG_DF_NAME, 8'h02, 8'hA0, 8'h00,
                          8'hA5, 8'h00,
                          8'h90, 8'h00};
        budget = '{250, 500, 150, 400};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // before any first byte the parser sits at the status bytes
        send_byte(8'h00, 1'b0, 10'h000);
        send_byte(8'hFF, 1'b0, 10'h3FF);
        send_byte(8'hA5, 1'b0, 10'h155);
        // every known tag, an oversized fixed field and an empty unknown element
        for (i = 0; i < directed_resp.size(); i++)
            send_byte(directed_resp[i], i == 0, LEN_W'(directed_resp.size()));

        for (ph = 0; ph < 4; ph++)
        begin
            write_mode(ph % 2 == 1);
            target = fields.bytes_in + budget[ph];
            while (fields.bytes_in < target)
            begin
                if (ph == 3 && fields.bytes_in > target - 200)
                    no_idle = 1'b1;
                if (no_idle)
                    calm = 1'b1;
                send_response();
            end
        end

        in_valid <= 1'b0;
        drain = 0;
        while (fields.pending() != 0 && drain < 1000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (5) @(posedge clk);
        if (fields.pending() != 0)
            fields.report($sformatf("%0d expected beats never arrived", fields.pending()));

        $display("Sent %0d bytes in %0d responses over both parse modes.",
                 fields.bytes_in, responses);
        $display("Matched %0d output beats, %0d of them status bytes.",
                 fields.matched, fields.status_seen);
        if (fields.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
